// ===== src/cltok_pkg.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Character codes and the flag set that the tokenizer carries from one
// character to the next.
// ----------------------------------------------------------------------------
package cltok_pkg;

    localparam int unsigned ByteW = 8;

    localparam logic [ByteW-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [ByteW-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [ByteW-1:0] CH_SQUOTE    = 8'h27;
    localparam logic [ByteW-1:0] CH_SLASH     = 8'h2F;
    localparam logic [ByteW-1:0] CH_SPACE     = 8'h20;
    localparam logic [ByteW-1:0] CH_EQUALS    = 8'h3D;

    typedef struct packed {
        logic escape_pending;
        logic quoted;
        logic prev_was_space;
        logic option_part;
        logic word_has_chars;
    } cltok_flags_t;

    localparam cltok_flags_t FLAGS_RESET = '{
        escape_pending: 1'b0,
        quoted:         1'b0,
        prev_was_space: 1'b0,
        option_part:    1'b0,
        word_has_chars: 1'b0
    };

endpackage

// ===== src/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer
// An accepted character is registered in stage 1, and its result in the output register.
// Throughput: one character per cycle while out_ready does not stall the output.
// Characters that close nothing or are dropped give no output transaction.
// Reset clears the flags and both pipeline valid bits at once.
// ----------------------------------------------------------------------------
module command_line_tokenizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cltok_pkg::ByteW-1:0]   text_byte,
    input  logic                          end_marker,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cltok_pkg::ByteW-1:0]   out_byte,
    output logic                          char_valid,
    output logic                          word_end,
    output logic                          in_option_list,
    output logic                          line_end
);

    logic                        s1_valid_reg;
    logic [cltok_pkg::ByteW-1:0] s1_byte_reg;
    logic                        s1_end_reg;
    logic                        s1_advance;

    cltok_pkg::cltok_flags_t     flags_reg;
    cltok_pkg::cltok_flags_t     flags_next;

    logic                        emit;
    logic [cltok_pkg::ByteW-1:0] byte_next;
    logic                        char_valid_next;
    logic                        word_end_next;
    logic                        option_next;
    logic                        line_end_next;

    logic                        res_valid_reg;
    logic [cltok_pkg::ByteW-1:0] out_byte_reg;
    logic                        char_valid_reg;
    logic                        word_end_reg;
    logic                        option_reg;
    logic                        line_end_reg;

    assign s1_advance = s1_valid_reg && (out_ready || !res_valid_reg);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= text_byte;
            s1_end_reg  <= end_marker;
        end
    end

    always_comb
    begin
        flags_next      = flags_reg;
        emit            = 1'b0;
        byte_next       = '0;
        char_valid_next = 1'b0;
        word_end_next   = 1'b0;
        option_next     = flags_reg.option_part;
        line_end_next   = 1'b0;

        if (s1_end_reg)
        begin
            emit          = 1'b1;
            word_end_next = flags_reg.word_has_chars;
            line_end_next = 1'b1;
            flags_next    = cltok_pkg::FLAGS_RESET;
        end
        else
        begin
            flags_next.prev_was_space = (s1_byte_reg == cltok_pkg::CH_SPACE);
            priority if (flags_reg.escape_pending)
            begin
                flags_next.escape_pending = 1'b0;
                flags_next.word_has_chars = 1'b1;
                emit                      = 1'b1;
                char_valid_next           = 1'b1;
                byte_next                 = s1_byte_reg;
            end
            else if (s1_byte_reg == cltok_pkg::CH_BACKSLASH)
            begin
                flags_next.escape_pending = 1'b1;
            end
            else if (s1_byte_reg == cltok_pkg::CH_DQUOTE
                     || s1_byte_reg == cltok_pkg::CH_SQUOTE)
            begin
                flags_next.quoted = !flags_reg.quoted;
            end
            else if (flags_reg.quoted)
            begin
                flags_next.word_has_chars = 1'b1;
                emit                      = 1'b1;
                char_valid_next           = 1'b1;
                byte_next                 = s1_byte_reg;
            end
            else if (s1_byte_reg == cltok_pkg::CH_SPACE && flags_reg.prev_was_space)
            begin
                emit = 1'b0;
            end
            else if (!flags_reg.option_part && s1_byte_reg == cltok_pkg::CH_SLASH)
            begin
                flags_next.word_has_chars = 1'b0;
                emit                      = flags_reg.word_has_chars;
                word_end_next             = 1'b1;
            end
            else if (s1_byte_reg == cltok_pkg::CH_SPACE
                     || s1_byte_reg == cltok_pkg::CH_EQUALS)
            begin
                flags_next.option_part    = 1'b1;
                flags_next.word_has_chars = 1'b0;
                emit                      = flags_reg.word_has_chars;
                word_end_next             = 1'b1;
            end
            else
            begin
                flags_next.word_has_chars = 1'b1;
                emit                      = 1'b1;
                char_valid_next           = 1'b1;
                byte_next                 = s1_byte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= cltok_pkg::FLAGS_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                flags_reg <= flags_next;
            end
            if (out_ready || !res_valid_reg)
            begin
                res_valid_reg <= s1_valid_reg && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_byte_reg   <= byte_next;
            char_valid_reg <= char_valid_next;
            word_end_reg   <= word_end_next;
            option_reg     <= option_next;
            line_end_reg   <= line_end_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign out_byte       = out_byte_reg;
    assign char_valid     = char_valid_reg;
    assign word_end       = word_end_reg;
    assign in_option_list = option_reg;
    assign line_end       = line_end_reg;

endmodule
